// ===== rtl/core/povsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// povsc_pkg
// Shared widths, register codes, reset values and types of the rotating
// display slice controller.
// ----------------------------------------------------------------------------
package povsc_pkg;

   // field widths
   localparam int TIME_W     = 32;
   localparam int LEVEL_W    = 12;
   localparam int SLICE_W    = 6;
   localparam int PIXEL_W    = 7;
   localparam int COLOR_W    = 24;
   localparam int PAIR_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // item kinds
   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERT_OFS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZ_OFS  = 2'd2;

   // register reset values
   localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 12'd2000;
   localparam logic [SLICE_W-1:0] VERT_OFS_RST  = 6'd45;
   localparam logic [SLICE_W-1:0] HORIZ_OFS_RST = 6'd15;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DIV_WAIT,
      ST_SCALE,
      ST_STEP
   } state_type;

   // frame store write request
   typedef struct packed {
      logic               we_even;
      logic               we_odd;
      logic [COLOR_W-1:0] data;
   } mem_wr_type;

endpackage

// ===== rtl/core/povsc_frame_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// povsc_frame_mem
// Frame store split into even and odd pixel banks, one pixel pair per
// address; one write port with per-bank enables, two registered read ports.
// ----------------------------------------------------------------------------
module povsc_frame_mem #(
   parameter int DEPTH  = 3300,
   parameter int ADDR_W = 12
) (
   input  logic                           clock,
   input  povsc_pkg::mem_wr_type          wr,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic                           rd_en,
   input  logic [ADDR_W-1:0]              rd_addr_a,
   input  logic [ADDR_W-1:0]              rd_addr_b,
   output logic [povsc_pkg::COLOR_W-1:0]  rd_a_even,
   output logic [povsc_pkg::COLOR_W-1:0]  rd_a_odd,
   output logic [povsc_pkg::COLOR_W-1:0]  rd_b_even,
   output logic [povsc_pkg::COLOR_W-1:0]  rd_b_odd
);

   logic [povsc_pkg::COLOR_W-1:0] even_mem [DEPTH];
   logic [povsc_pkg::COLOR_W-1:0] odd_mem  [DEPTH];

   logic [povsc_pkg::COLOR_W-1:0] a_even_ff, a_odd_ff, b_even_ff, b_odd_ff;

   always_ff @(posedge clock) begin
      if (wr.we_even) begin
         even_mem[wr_addr] <= wr.data;
      end
      if (wr.we_odd) begin
         odd_mem[wr_addr] <= wr.data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         a_even_ff <= even_mem[rd_addr_a];
         a_odd_ff  <= odd_mem[rd_addr_a];
         b_even_ff <= even_mem[rd_addr_b];
         b_odd_ff  <= odd_mem[rd_addr_b];
      end
   end

   assign rd_a_even = a_even_ff;
   assign rd_a_odd  = a_odd_ff;
   assign rd_b_even = b_even_ff;
   assign rd_b_odd  = b_odd_ff;

endmodule

// ===== rtl/core/povsc_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// povsc_divider
// Division of a time value by a fixed slice count through a reciprocal
// multiply and one correction step; done is registered with the quotient.
// ----------------------------------------------------------------------------
module povsc_divider #(
   parameter int DIVISOR = 60
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [povsc_pkg::TIME_W-1:0]  dividend,
   output logic                          done,
   output logic [povsc_pkg::TIME_W-1:0]  quotient
);

   localparam int TW    = povsc_pkg::TIME_W;
   // reciprocal scaled so it fits in TW bits; the estimate is at most one low
   localparam int SHIFT = TW - 1 + $clog2(DIVISOR);
   localparam logic [TW-1:0] RECIP = TW'((64'd1 << SHIFT) / 64'(DIVISOR));

   logic              mul_ff, mul_in;
   logic              fix_ff, fix_in;
   logic              done_ff, done_in;
   logic [TW-1:0]     num_ff, num_in;
   logic [2*TW-1:0]   prod_ff, prod_in;
   logic [TW-1:0]     quo_ff, quo_in;
   logic [TW-1:0]     est;
   logic [TW-1:0]     rem;

   // quotient estimate and what is left over after it
   assign est = TW'(prod_ff >> SHIFT);
   assign rem = num_ff - TW'(est * TW'(DIVISOR));

   always_comb begin
      mul_in  = 1'b0;
      fix_in  = 1'b0;
      done_in = done_ff;
      num_in  = num_ff;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      if (start) begin
         num_in  = dividend;
         mul_in  = 1'b1;
         done_in = 1'b0;
      end else begin
         if (mul_ff) begin
            prod_in = (2*TW)'(num_ff) * (2*TW)'(RECIP);
            fix_in  = 1'b1;
         end
         if (fix_ff) begin
            quo_in  = (rem >= TW'(DIVISOR)) ? (est + 1'b1) : est;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/pov_display_slice_controller.sv =====
// pixel writes can follow back to back
// a tick's first pair passes the memory read registers and then the output word,
// then one pair per cycle while rsp_stall is low; a tick stalls the input through
// the read, divide-wait, scale and step states; the divide runs alongside the reads
// after reset a clearing pass over all SLICES*PAIRS addresses (3300 by default) zeroes
// the frame store while req_stall is high; configuration writes are taken throughout
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pov_display_slice_controller
// Slice timing and strip refresh for a rotating two-strip LED display, with
// the frame store held in a two-bank synchronous memory.
// ----------------------------------------------------------------------------
module pov_display_slice_controller #(
   parameter int SLICES = 60,
   parameter int PIXELS = 110
) (
   input  logic                              clock,
   input  logic                              reset,
   // item input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [povsc_pkg::TIME_W-1:0]      req_now_us,
   input  logic [povsc_pkg::LEVEL_W-1:0]     req_sensor_level,
   input  logic [povsc_pkg::SLICE_W-1:0]     req_write_slice,
   input  logic [povsc_pkg::PIXEL_W-1:0]     req_write_pixel,
   input  logic [povsc_pkg::COLOR_W-1:0]     req_write_color,
   // pixel pair output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [povsc_pkg::PAIR_W-1:0]      rsp_pair_index,
   output logic [povsc_pkg::COLOR_W-1:0]     rsp_vert_color_even,
   output logic [povsc_pkg::COLOR_W-1:0]     rsp_vert_color_odd,
   output logic [povsc_pkg::COLOR_W-1:0]     rsp_horiz_color_even,
   output logic [povsc_pkg::COLOR_W-1:0]     rsp_horiz_color_odd,
   output logic                              rsp_last_pair,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [povsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [povsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PAIRS  = (PIXELS + 1) / 2;
   localparam int DEPTH  = SLICES * PAIRS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SUM_W  = povsc_pkg::SLICE_W + 1;
   localparam int TW     = povsc_pkg::TIME_W;
   localparam int PROD_W = TW + SUM_W;

   // (slice + offset) mod SLICES by compare and subtract of shifted divisors
   function automatic logic [povsc_pkg::SLICE_W-1:0] slice_wrap(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] rem;
      rem = sum;
      for (int k = SUM_W - 1; k >= 0; k--) begin
         if (int'(rem) >= (SLICES << k)) begin
            rem = rem - SUM_W'(SLICES << k);
         end
      end
      return rem[povsc_pkg::SLICE_W-1:0];
   endfunction

   // sequencer
   povsc_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [povsc_pkg::LEVEL_W-1:0] threshold_ff;
   logic [povsc_pkg::SLICE_W-1:0] vert_ofs_ff;
   logic [povsc_pkg::SLICE_W-1:0] horiz_ofs_ff;

   // rotation timing state
   logic                          armed_ff, armed_in;
   logic [TW-1:0]                 index_time_ff, index_time_in;
   logic [TW-1:0]                 period_ff, period_in;
   logic [povsc_pkg::SLICE_W-1:0] cur_slice_ff;
   logic [TW-1:0]                 elapsed_ff, elapsed_in;
   logic [PROD_W-1:0]             limit_ff;
   logic                          measured;

   // refresh state
   logic [povsc_pkg::SLICE_W-1:0] vslice_ff, hslice_ff;
   logic [povsc_pkg::PAIR_W-1:0]  pair_ff;
   logic [ADDR_W-1:0]             clear_cnt_ff;

   // read stage (data sits in the memory read registers) and output word
   logic                          mem_valid_ff, mem_valid_in;
   logic [povsc_pkg::PAIR_W-1:0]  mem_pair_ff;
   logic                          mem_last_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [povsc_pkg::PAIR_W-1:0]  rsp_pair_ff;
   logic                          rsp_last_ff;
   logic [povsc_pkg::COLOR_W-1:0] rsp_ve_ff, rsp_vo_ff, rsp_he_ff, rsp_ho_ff;

   // sequencer outputs
   logic                          idle;
   logic                          clearing;
   logic                          reading;
   logic                          scale_en;
   logic                          step_en;

   // handshakes and flow
   logic                          req_accept;
   logic                          tick_accept;
   logic                          write_accept;
   logic                          write_in_range;
   logic                          out_take;
   logic                          out_free;
   logic                          move;
   logic                          issue;
   logic                          last_issue;
   logic                          csr_accept;

   // memory ports
   povsc_pkg::mem_wr_type         mem_wr;
   logic [ADDR_W-1:0]             mem_wr_addr;
   logic [ADDR_W-1:0]             vert_addr, horiz_addr;
   logic [povsc_pkg::COLOR_W-1:0] rd_ve, rd_vo, rd_he, rd_ho;

   // period divider
   logic                          div_done;
   logic [TW-1:0]                 div_quot;

   // slice advance
   logic [SUM_W-1:0]              cur_plus;
   logic [povsc_pkg::SLICE_W-1:0] cur_next;

   // ---------------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------------
   assign req_stall    = !idle;
   assign req_accept   = req_valid && !req_stall;
   assign tick_accept  = req_accept && (req_action == povsc_pkg::ACT_TICK);
   assign write_accept = req_accept && (req_action == povsc_pkg::ACT_WRITE);

   // writes off the edge of the store are dropped
   assign write_in_range = (SUM_W'(req_write_slice) < SUM_W'(SLICES)) &&
                           ((povsc_pkg::PIXEL_W + 1)'(req_write_pixel) <
                            (povsc_pkg::PIXEL_W + 1)'(PIXELS));

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   // output word and the read stage in front of it act as a two-deep queue
   assign out_take   = rsp_valid_ff && !rsp_stall;
   assign out_free   = !rsp_valid_ff || out_take;
   assign move       = mem_valid_ff && out_free;
   assign issue      = reading && (!mem_valid_ff || move);
   assign last_issue = (pair_ff == povsc_pkg::PAIR_W'(PAIRS - 1));

   // ---------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         povsc_pkg::ST_CLEAR: begin
            if (clear_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = povsc_pkg::ST_IDLE;
            end
         end
         povsc_pkg::ST_IDLE: begin
            if (tick_accept) begin
               state_in = povsc_pkg::ST_READ;
            end
         end
         povsc_pkg::ST_READ: begin
            if (issue && last_issue) begin
               state_in = povsc_pkg::ST_DIV_WAIT;
            end
         end
         povsc_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = povsc_pkg::ST_SCALE;
            end
         end
         povsc_pkg::ST_SCALE: begin
            state_in = povsc_pkg::ST_STEP;
         end
         povsc_pkg::ST_STEP: begin
            state_in = povsc_pkg::ST_IDLE;
         end
         default: begin
            state_in = povsc_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // sequencer: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      idle     = 1'b0;
      clearing = 1'b0;
      reading  = 1'b0;
      scale_en = 1'b0;
      step_en  = 1'b0;
      unique case (state_ff)
         povsc_pkg::ST_CLEAR:    clearing = 1'b1;
         povsc_pkg::ST_IDLE:     idle     = 1'b1;
         povsc_pkg::ST_READ:     reading  = 1'b1;
         povsc_pkg::ST_DIV_WAIT: idle     = 1'b0;
         povsc_pkg::ST_SCALE:    scale_en = 1'b1;
         povsc_pkg::ST_STEP:     step_en  = 1'b1;
         default:                idle     = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= povsc_pkg::ST_CLEAR;
         clear_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) begin
            clear_cnt_ff <= clear_cnt_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= povsc_pkg::THRESHOLD_RST;
         vert_ofs_ff  <= povsc_pkg::VERT_OFS_RST;
         horiz_ofs_ff <= povsc_pkg::HORIZ_OFS_RST;
      end else if (csr_accept) begin
         unique case (csr_index)
            povsc_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata;
            povsc_pkg::CSR_VERT_OFS:  vert_ofs_ff  <= csr_wdata[povsc_pkg::SLICE_W-1:0];
            povsc_pkg::CSR_HORIZ_OFS: horiz_ofs_ff <= csr_wdata[povsc_pkg::SLICE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // index mark detection on a tick
   // ---------------------------------------------------------------------
   // armed sample below the threshold measures the period and disarms,
   // a disarmed sample above it re-arms, equal changes nothing
   assign measured = armed_ff && (req_sensor_level < threshold_ff);

   always_comb begin
      armed_in      = armed_ff;
      index_time_in = index_time_ff;
      period_in     = period_ff;
      elapsed_in    = req_now_us - index_time_ff;
      if (measured) begin
         period_in     = req_now_us - index_time_ff;
         index_time_in = req_now_us;
         armed_in      = 1'b0;
         elapsed_in    = '0;
      end else if (!armed_ff && (req_sensor_level > threshold_ff)) begin
         armed_in = 1'b1;
      end
   end

   // slice advances once the elapsed time passes its share of the period
   assign cur_plus = SUM_W'(cur_slice_ff) + 1'b1;
   assign cur_next = (cur_plus >= SUM_W'(SLICES)) ? '0 : cur_plus[povsc_pkg::SLICE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= 1'b1;
         index_time_ff <= '0;
         period_ff     <= '0;
         cur_slice_ff  <= '0;
      end else begin
         if (tick_accept) begin
            armed_ff      <= armed_in;
            index_time_ff <= index_time_in;
            period_ff     <= period_in;
         end
         if (step_en && ({{SUM_W{1'b0}}, elapsed_ff} > limit_ff)) begin
            cur_slice_ff <= cur_next;
         end
      end
   end

   // strip slices and elapsed time are fixed for the whole tick
   always_ff @(posedge clock) begin
      if (tick_accept) begin
         elapsed_ff <= elapsed_in;
         vslice_ff  <= slice_wrap(SUM_W'(cur_slice_ff) + SUM_W'(vert_ofs_ff));
         hslice_ff  <= slice_wrap(SUM_W'(cur_slice_ff) + SUM_W'(horiz_ofs_ff));
      end
      if (scale_en) begin
         limit_ff <= {{SUM_W{1'b0}}, div_quot} * {{TW{1'b0}}, cur_plus};
      end
   end

   povsc_divider #(
      .DIVISOR (SLICES)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (tick_accept),
      .dividend (period_in),
      .done     (div_done),
      .quotient (div_quot)
   );

   // ---------------------------------------------------------------------
   // frame store access
   // ---------------------------------------------------------------------
   // the clearing pass zeroes one pair a cycle; pixel writes only in idle,
   // so they never overlap a refresh read
   always_comb begin
      mem_wr.we_even = 1'b0;
      mem_wr.we_odd  = 1'b0;
      mem_wr.data    = req_write_color;
      mem_wr_addr    = ADDR_W'(req_write_slice) * ADDR_W'(PAIRS) +
                       ADDR_W'(req_write_pixel[povsc_pkg::PIXEL_W-1:1]);
      if (clearing) begin
         mem_wr.we_even = 1'b1;
         mem_wr.we_odd  = 1'b1;
         mem_wr.data    = '0;
         mem_wr_addr    = clear_cnt_ff;
      end else if (write_accept && write_in_range) begin
         mem_wr.we_even = !req_write_pixel[0];
         mem_wr.we_odd  = req_write_pixel[0];
      end
   end

   assign vert_addr  = ADDR_W'(vslice_ff) * ADDR_W'(PAIRS) + ADDR_W'(pair_ff);
   assign horiz_addr = ADDR_W'(hslice_ff) * ADDR_W'(PAIRS) + ADDR_W'(pair_ff);

   povsc_frame_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_frame_mem (
      .clock     (clock),
      .wr        (mem_wr),
      .wr_addr   (mem_wr_addr),
      .rd_en     (issue),
      .rd_addr_a (vert_addr),
      .rd_addr_b (horiz_addr),
      .rd_a_even (rd_ve),
      .rd_a_odd  (rd_vo),
      .rd_b_even (rd_he),
      .rd_b_odd  (rd_ho)
   );

   // ---------------------------------------------------------------------
   // refresh readout and output word
   // ---------------------------------------------------------------------
   assign mem_valid_in = issue || (mem_valid_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && !out_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff      <= '0;
         mem_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mem_valid_ff <= mem_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tick_accept) begin
            pair_ff <= '0;
         end else if (issue) begin
            pair_ff <= pair_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         mem_pair_ff <= pair_ff;
         mem_last_ff <= last_issue;
      end
      if (move) begin
         rsp_pair_ff <= mem_pair_ff;
         rsp_last_ff <= mem_last_ff;
         rsp_ve_ff   <= rd_ve;
         rsp_vo_ff   <= rd_vo;
         rsp_he_ff   <= rd_he;
         rsp_ho_ff   <= rd_ho;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pair_index       = rsp_pair_ff;
   assign rsp_vert_color_even  = rsp_ve_ff;
   assign rsp_vert_color_odd   = rsp_vo_ff;
   assign rsp_horiz_color_even = rsp_he_ff;
   assign rsp_horiz_color_odd  = rsp_ho_ff;
   assign rsp_last_pair        = rsp_last_ff;

endmodule
